/* rtl/ipv4dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_pkg
// Shared types and constants of the dotted-decimal IPv4 text parser.
// ----------------------------------------------------------------------------
package ipv4dq_pkg;

   localparam logic [7:0]  SymDot       = 8'h2E;
   localparam logic [7:0]  SymZero      = 8'h30;
   localparam logic [7:0]  SymNine      = 8'h39;
   localparam logic [11:0] FieldMax     = 12'd255;
   localparam logic [11:0] Radix        = 12'd10;
   localparam logic [4:0]  LenMin       = 5'd7;
   localparam logic [4:0]  LenMax       = 5'd15;
   localparam logic [4:0]  LenSat       = 5'd16;
   localparam logic [2:0]  FieldsNeeded = 3'd4;

   typedef struct packed {
      logic [4:0]  text_length;
      logic [7:0]  field_value;
      logic [2:0]  field_count;
      logic        after_dot;
      logic        format_error;
      logic [31:0] address_acc;
   } parse_state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] symbol;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic        is_valid;
      logic [31:0] address_value;
   } rsp_item_type;

endpackage

/* rtl/ipv4dq_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_req_if / ipv4dq_rsp_if
// Valid/ready channels for text characters and parse results.
// ----------------------------------------------------------------------------
interface ipv4dq_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_text;

   modport source (output valid, output symbol, output end_of_text, input ready);
   modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

interface ipv4dq_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_valid;
   logic [31:0] address_value;

   modport source (output valid, output is_valid, output address_value, input ready);
   modport sink   (input valid, input is_valid, input address_value, output ready);
endinterface

/* rtl/ipv4_dotted_quad_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_parser
// The parse state is one register; each result is registered in the result register.
// One character per cycle, but an end-of-text character waits in the input
// register while a result stalls at the output; other characters still pass.
// Reset (synchronous): empties both registers and clears the parse state.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_parser (
   input  logic         clock,
   input  logic         reset,
   ipv4dq_req_if.sink   req_bus,
   ipv4dq_rsp_if.source rsp_bus
);
   import ipv4dq_pkg::*;

   req_item_type    item;
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_next;
   rsp_item_type    step_result;
   logic            can_load;
   logic            take;

   // a character without the end mark never needs the result register
   assign take = item.valid && (!item.end_of_text || can_load);

   ipv4dq_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .take    (take),
      .item    (item)
   );

   ipv4dq_step u_step (
      .cur         (state_ff),
      .symbol      (item.symbol),
      .end_of_text (item.end_of_text),
      .nxt         (step_next),
      .result      (step_result)
   );

   always_comb begin
      state_in = state_ff;
      if (take) begin
         state_in = step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   ipv4dq_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take && item.end_of_text),
      .result   (step_result),
      .can_load (can_load),
      .rsp_bus  (rsp_bus)
   );

endmodule

/* rtl/ipv4dq_in_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_in_reg
// Input register: holds one request character until the parse stage takes it.
// ----------------------------------------------------------------------------
module ipv4dq_in_reg (
   input  logic                    clock,
   input  logic                    reset,
   ipv4dq_req_if.sink              req_bus,
   input  logic                    take,
   output ipv4dq_pkg::req_item_type item
);
   import ipv4dq_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] symbol_ff;
   logic       eot_ff;

   assign req_bus.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_bus.ready) begin
         valid_in = req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         symbol_ff <= req_bus.symbol;
         eot_ff    <= req_bus.end_of_text;
      end
   end

   assign item.valid       = valid_ff;
   assign item.symbol      = symbol_ff;
   assign item.end_of_text = eot_ff;

endmodule

/* rtl/ipv4dq_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_step
// Per-character parse update: next parse state and the end-of-text result.
// ----------------------------------------------------------------------------
module ipv4dq_step (
   input  ipv4dq_pkg::parse_state_type cur,
   input  logic [7:0]                  symbol,
   input  logic                        end_of_text,
   output ipv4dq_pkg::parse_state_type nxt,
   output ipv4dq_pkg::rsp_item_type    result
);
   import ipv4dq_pkg::*;

   logic [11:0]     digit_sum;
   logic [7:0]      digit_raw;
   logic            is_dot;
   logic            is_digit;
   logic            close_req;
   parse_state_type st;

   assign digit_raw = symbol - SymZero;
   assign digit_sum = {4'd0, cur.field_value} * Radix + {8'd0, digit_raw[3:0]};
   assign is_dot    = (symbol == SymDot);
   assign is_digit  = (symbol >= SymZero) && (symbol <= SymNine);

   always_comb begin
      st        = cur;
      close_req = 1'b0;

      if (cur.text_length < LenSat) begin
         st.text_length = cur.text_length + 5'd1;
      end

      if (!cur.format_error) begin
         priority if (is_dot) begin
            if (cur.after_dot) begin
               st.format_error = 1'b1;
            end else begin
               st.after_dot = 1'b1;
               close_req    = 1'b1;
            end
         end else if (is_digit) begin
            st.after_dot = 1'b0;
            if (digit_sum > FieldMax) begin
               st.format_error = 1'b1;
            end else begin
               st.field_value = digit_sum[7:0];
            end
         end else begin
            st.format_error = 1'b1;
         end
      end

      // end mark closes the open field unless a dot just closed one or an error is set
      if (end_of_text && !st.format_error && !st.after_dot) begin
         close_req = 1'b1;
      end

      if (close_req) begin
         if (st.field_count >= FieldsNeeded) begin
            st.format_error = 1'b1;
         end else begin
            st.address_acc = {st.address_acc[23:0], st.field_value};
            st.field_count = st.field_count + 3'd1;
            st.field_value = 8'd0;
         end
      end

      result.is_valid = !st.format_error && (st.field_count == FieldsNeeded) &&
                        (st.text_length >= LenMin) && (st.text_length <= LenMax);
      result.address_value = result.is_valid ? st.address_acc : 32'd0;

      if (end_of_text) begin
         nxt = '0;
      end else begin
         nxt = st;
      end
   end

endmodule

/* rtl/ipv4dq_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_out_reg
// Result register: holds one parse result until the sink takes it.
// ----------------------------------------------------------------------------
module ipv4dq_out_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  ipv4dq_pkg::rsp_item_type result,
   output logic                     can_load,
   ipv4dq_rsp_if.source             rsp_bus
);
   import ipv4dq_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign can_load = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && can_load) begin
         data_ff <= result;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.is_valid      = data_ff.is_valid;
   assign rsp_bus.address_value = data_ff.address_value;

endmodule

/* rtl/ipv4dq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4dq_checker
// Port-level checks of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4dq_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_is_valid,
   input logic [31:0] rsp_address_value
);

   // result register comes out of reset empty
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_is_valid) &&
                                  $stable(rsp_address_value))
      else $error("stalled result changed");

   // rejected text reports a zero address
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_valid |-> rsp_address_value == 32'd0)
      else $error("invalid result with nonzero address");

   // with the result register empty nothing can stall the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_ipv4dq_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_bus.ready),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_is_valid      (rsp_bus.is_valid),
   .rsp_address_value (rsp_bus.address_value)
);
